// ===== rtl/core/a64x_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_pkg
// Types and constants shared by the A64 subset execute unit.
// ----------------------------------------------------------------------------
package a64x_pkg;

   localparam int          REG_COUNT      = 31;
   localparam logic [4:0]  ZERO_REG       = 5'd31;
   localparam logic [63:0] START_PC_RESET = 64'h0000_0000_0040_0000;
   localparam int          BANKS          = 8;

   typedef enum logic [4:0] {
      OP_ADDI    = 5'd0,
      OP_ADDREG  = 5'd1,
      OP_ADDSI   = 5'd2,
      OP_ADDSREG = 5'd3,
      OP_SUBSI   = 5'd4,
      OP_SUBSREG = 5'd5,
      OP_MUL     = 5'd6,
      OP_ANDS    = 5'd7,
      OP_EOR     = 5'd8,
      OP_ORR     = 5'd9,
      OP_MOVZ    = 5'd10,
      OP_STUR    = 5'd11,
      OP_STURB   = 5'd12,
      OP_STURH   = 5'd13,
      OP_LDUR    = 5'd14,
      OP_LDURB   = 5'd15,
      OP_LDURH   = 5'd16,
      OP_B       = 5'd17,
      OP_BR      = 5'd18,
      OP_BCOND   = 5'd19,
      OP_CBZ     = 5'd20,
      OP_CBNZ    = 5'd21,
      OP_LSL_LSR = 5'd22,
      OP_HLT     = 5'd23
   } a64x_op_type;

   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;

   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;

   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_HALF = 2'd1,
      SZ_DWORD = 2'd2
   } a64x_size_type;

   typedef struct packed {
      logic [4:0]  op;
      logic [31:0] instr_word;
   } a64x_req_type;

   typedef struct packed {
      logic [63:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [63:0] reg_value;
      logic        negative_flag;
      logic        zero_flag;
      logic        halted;
   } a64x_rsp_type;

   typedef struct packed {
      logic [63:0]   next_pc;
      logic          we;
      logic [4:0]    idx;
      logic [63:0]   value;
      logic          flag_n;
      logic          flag_z;
      logic          halt;
      logic          mem_rd;
      logic          mem_wr;
      a64x_size_type size;
      logic [63:0]   addr;
      logic [63:0]   sdata;
      logic          is_mul;
      logic [63:0]   pp_lo;
      logic [31:0]   pp_cross;
   } a64x_ex_type;

   // second register port carries rt for stores and compare branches
   function automatic logic uses_rt(input logic [4:0] op);
      logic r;
      r = (op == OP_STUR) || (op == OP_STURB) || (op == OP_STURH) ||
          (op == OP_CBZ) || (op == OP_CBNZ);
      return r;
   endfunction

endpackage

// ===== rtl/core/a64x_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_ram
// Byte-wide data memory bank, one write and one registered read port.
// ----------------------------------------------------------------------------
module a64x_ram #(
   parameter int ROWS = 512
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(ROWS)-1:0]   waddr,
   input  logic [7:0]                wdata,
   input  logic                      re,
   input  logic [$clog2(ROWS)-1:0]   raddr,
   output logic [7:0]                rdata
);

   logic [7:0] mem [ROWS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/a64x_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_regfile
// 31 x 64 register file, two registered read ports with write bypass.
// ----------------------------------------------------------------------------
module a64x_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr0,
   input  logic [4:0]  rd_addr1,
   output logic [63:0] rd_data0,
   output logic [63:0] rd_data1,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [63:0] wr_data
);
   import a64x_pkg::*;

   logic [63:0]          regs [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [63:0]          rd_data0_ff;
   logic [63:0]          rd_data1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && wr_addr != ZERO_REG) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr != ZERO_REG) begin
         regs[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_addr0 == ZERO_REG) begin
            rd_data0_ff <= '0;
         end else if (wr_en && wr_addr == rd_addr0) begin
            rd_data0_ff <= wr_data;
         end else if (valid_ff[rd_addr0] && !reset) begin
            rd_data0_ff <= regs[rd_addr0];
         end else begin
            rd_data0_ff <= '0;
         end
         if (rd_addr1 == ZERO_REG) begin
            rd_data1_ff <= '0;
         end else if (wr_en && wr_addr == rd_addr1) begin
            rd_data1_ff <= wr_data;
         end else if (valid_ff[rd_addr1] && !reset) begin
            rd_data1_ff <= regs[rd_addr1];
         end else begin
            rd_data1_ff <= '0;
         end
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== rtl/core/a64x_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_exec
// Execute logic: operands, immediates, branches, flags and memory request.
// ----------------------------------------------------------------------------
module a64x_exec (
   input  a64x_pkg::a64x_req_type req,
   input  logic [63:0]            xn,
   input  logic [63:0]            xm,
   input  logic [63:0]            pc,
   input  logic                   flag_n,
   input  logic                   flag_z,
   input  logic                   halted,
   output a64x_pkg::a64x_ex_type  ex
);
   import a64x_pkg::*;

   logic [31:0] w;
   logic [4:0]  rd;
   logic [63:0] imm12;
   logic [63:0] imm12_s;
   logic [63:0] rm_shifted;
   logic [63:0] movz_val;
   logic [63:0] mem_addr;
   logic [63:0] br26;
   logic [63:0] br19;
   logic [5:0]  immr;
   logic        cond_ok;
   logic [63:0] pp_lo;
   logic [31:0] pp_cross;
   logic [63:0] res;
   logic        set_nz;

   assign w        = req.instr_word;
   assign rd       = w[4:0];
   assign imm12    = {52'd0, w[21:10]};
   assign imm12_s  = (w[23:22] == 2'd1) ? (imm12 << 12) : imm12;
   assign movz_val = {48'd0, w[20:5]} << {w[22:21], 4'd0};
   assign mem_addr = xn + {{55{w[20]}}, w[20:12]};
   assign br26     = {{36{w[25]}}, w[25:0], 2'b00};
   assign br19     = {{43{w[23]}}, w[23:5], 2'b00};
   assign immr     = w[21:16];
   assign pp_lo    = xn[31:0] * xm[31:0];
   assign pp_cross = xn[31:0] * xm[63:32] + xn[63:32] * xm[31:0];

   always_comb begin
      case (w[22:23-1] == 1'b0 ? w[23:22] : w[23:22])
         SHIFT_LSL: rm_shifted = xm << w[15:10];
         SHIFT_LSR: rm_shifted = xm >> w[15:10];
         default:   rm_shifted = xm;
      endcase
   end

   always_comb begin
      case (w[3:0])
         COND_EQ: cond_ok = flag_z;
         COND_NE: cond_ok = !flag_z;
         COND_GE: cond_ok = !flag_n;
         COND_LT: cond_ok = flag_n;
         COND_GT: cond_ok = !flag_n && !flag_z;
         COND_LE: cond_ok = flag_z || flag_n;
         default: cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      res    = '0;
      set_nz = 1'b0;
      ex          = '0;
      ex.next_pc  = pc + 64'd4;
      ex.idx      = rd;
      ex.flag_n   = flag_n;
      ex.flag_z   = flag_z;
      ex.halt     = halted;
      ex.size     = SZ_DWORD;
      ex.addr     = mem_addr;
      ex.sdata    = xm;
      ex.pp_lo    = pp_lo;
      ex.pp_cross = pp_cross;
      if (halted) begin
         ex.next_pc = pc;
      end else begin
         case (req.op)
            OP_ADDI: begin
               res   = xn + (w[22] ? (imm12 << 12) : imm12);
               ex.we = 1'b1;
            end
            OP_ADDREG: begin
               res   = xn + rm_shifted;
               ex.we = 1'b1;
            end
            OP_ADDSI: begin
               res    = xn + imm12_s;
               set_nz = 1'b1;
               ex.we  = 1'b1;
            end
            OP_SUBSI: begin
               res    = xn - imm12_s;
               set_nz = 1'b1;
               ex.we  = 1'b1;
            end
            OP_ADDSREG: begin
               res    = xn + xm;
               set_nz = 1'b1;
               ex.we  = 1'b1;
            end
            OP_SUBSREG: begin
               res    = xn - xm;
               set_nz = 1'b1;
               ex.we  = 1'b1;
            end
            OP_MUL: begin
               ex.is_mul = 1'b1;
               ex.we     = 1'b1;
            end
            OP_ANDS: begin
               res    = xn & xm;
               set_nz = 1'b1;
               ex.we  = 1'b1;
            end
            OP_EOR: begin
               res   = xn ^ xm;
               ex.we = 1'b1;
            end
            OP_ORR: begin
               res   = xn | xm;
               ex.we = 1'b1;
            end
            OP_MOVZ: begin
               res   = movz_val;
               ex.we = 1'b1;
            end
            OP_STUR: begin
               ex.mem_wr = 1'b1;
            end
            OP_STURB: begin
               ex.mem_wr = 1'b1;
               ex.size   = SZ_BYTE;
            end
            OP_STURH: begin
               ex.mem_wr = 1'b1;
               ex.size   = SZ_HALF;
            end
            OP_LDUR: begin
               ex.mem_rd = 1'b1;
               ex.we     = 1'b1;
            end
            OP_LDURB: begin
               ex.mem_rd = 1'b1;
               ex.size   = SZ_BYTE;
               ex.we     = 1'b1;
            end
            OP_LDURH: begin
               ex.mem_rd = 1'b1;
               ex.size   = SZ_HALF;
               ex.we     = 1'b1;
            end
            OP_B: begin
               ex.next_pc = pc + br26;
            end
            OP_BR: begin
               ex.next_pc = xn;
            end
            OP_BCOND: begin
               if (cond_ok) begin
                  ex.next_pc = pc + br19;
               end
            end
            OP_CBZ: begin
               if (xm == 64'd0) begin
                  ex.next_pc = pc + br19;
               end
            end
            OP_CBNZ: begin
               if (xm != 64'd0) begin
                  ex.next_pc = pc + br19;
               end
            end
            OP_LSL_LSR: begin
               if (w[31] && w[22]) begin
                  if (w[15:10] != 6'h3F) begin
                     res = xn << (6'd0 - immr);
                  end else begin
                     res = xn >> immr;
                  end
                  ex.we = 1'b1;
               end
            end
            OP_HLT: begin
               ex.halt = 1'b1;
            end
            default: begin
               ex.we = 1'b0;
            end
         endcase
      end
      if (set_nz) begin
         ex.flag_n = res[63];
         ex.flag_z = (res == 64'd0);
      end
      if (rd == ZERO_REG) begin
         ex.we = 1'b0;
      end
      ex.value = ex.we ? res : 64'd0;
   end

endmodule

// ===== rtl/core/arm64_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_subset_execute_unit
// Executes one decoded A64 subset instruction per transfer, with registers,
// PC, N/Z flags, halt bit and a banked little-endian byte data memory.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  req     | req_valid req_stall req_payload | in
//  rsp     | rsp_valid rsp_stall rsp_payload | out
//  csr     | csr_wr_en csr_wr_data           | in
//
//  one instruction per cycle while req_stall is low; rsp_valid rises once its transfer
//  has passed register read, execute and memory access, and load/multiply merge
//  after reset the data memory is cleared row by row, with req_stall high
//  rsp_stall with a result waiting freezes all stages and raises req_stall
// ----------------------------------------------------------------------------
module arm64_subset_execute_unit #(
   parameter int DMEM_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  a64x_pkg::a64x_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output a64x_pkg::a64x_rsp_type rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [63:0]            csr_wr_data
);
   import a64x_pkg::*;

   localparam int AW   = $clog2(DMEM_BYTES);
   localparam int ROWS = DMEM_BYTES / BANKS;
   localparam int RW   = $clog2(ROWS);

   logic         adv;
   logic         accept;
   logic         x_vld_ff, m_vld_ff, o_vld_ff;
   a64x_req_type x_ff;
   a64x_ex_type  m_ff;
   a64x_rsp_type o_ff, o_in;
   a64x_ex_type  ex;
   logic [63:0]  pc_ff;
   logic         flag_n_ff, flag_z_ff, halted_ff;
   logic [63:0]  start_pc_ff;
   logic         clr_busy_ff;
   logic [RW-1:0] clr_row_ff;

   logic [63:0]  rf_d0, rf_d1, xn, xm;
   logic [63:0]  m_final, load_val, load_rot;
   logic [127:0] load_dbl;
   logic [63:0]  bank_data;
   logic [RW-1:0] bank_row [BANKS];
   logic [RW-1:0] bank_waddr [BANKS];
   logic [7:0]   bank_wdata [BANKS];
   logic [BANKS-1:0] bank_we;
   logic         mem_re;

   assign adv       = !o_vld_ff || !rsp_stall;
   assign req_stall = !adv || clr_busy_ff;
   assign accept    = req_valid && !req_stall;

   // register file
   a64x_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (adv),
      .rd_addr0 (req_payload.instr_word[9:5]),
      .rd_addr1 (uses_rt(req_payload.op) ? req_payload.instr_word[4:0]
                                         : req_payload.instr_word[20:16]),
      .rd_data0 (rf_d0),
      .rd_data1 (rf_d1),
      .wr_en    (adv && m_vld_ff && m_ff.we),
      .wr_addr  (m_ff.idx),
      .wr_data  (m_final)
   );

   // forward from the instruction one stage ahead
   always_comb begin
      xn = rf_d0;
      xm = rf_d1;
      if (m_vld_ff && m_ff.we && m_ff.idx == x_ff.instr_word[9:5]) begin
         xn = m_final;
      end
      if (m_vld_ff && m_ff.we &&
          m_ff.idx == (uses_rt(x_ff.op) ? x_ff.instr_word[4:0] : x_ff.instr_word[20:16])) begin
         xm = m_final;
      end
   end

   a64x_exec u_exec (
      .req    (x_ff),
      .xn     (xn),
      .xm     (xm),
      .pc     (pc_ff),
      .flag_n (flag_n_ff),
      .flag_z (flag_z_ff),
      .halted (halted_ff),
      .ex     (ex)
   );

   // data memory banks, bank b holds bytes whose address mod 8 is b
   assign mem_re = adv && x_vld_ff && ex.mem_rd;

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         logic [2:0] i;
         i = 3'(b) - ex.addr[2:0];
         bank_row[b] = ex.addr[AW-1:3] + RW'(3'(b) < ex.addr[2:0]);
         case (ex.size)
            SZ_BYTE: bank_we[b] = (i == 3'd0);
            SZ_HALF: bank_we[b] = (i < 3'd2);
            default: bank_we[b] = 1'b1;
         endcase
         bank_we[b] = clr_busy_ff || (bank_we[b] && adv && x_vld_ff && ex.mem_wr);
         bank_waddr[b] = clr_busy_ff ? clr_row_ff : bank_row[b];
         bank_wdata[b] = clr_busy_ff ? 8'd0 : 8'(ex.sdata >> {i, 3'b000});
      end
   end

   for (genvar g = 0; g < BANKS; g++) begin : g_bank
      a64x_ram #(
         .ROWS (ROWS)
      ) u_ram (
         .clock (clock),
         .we    (bank_we[g]),
         .waddr (bank_waddr[g]),
         .wdata (bank_wdata[g]),
         .re    (mem_re),
         .raddr (bank_row[g]),
         .rdata (bank_data[8*g +: 8])
      );
   end

   // load merge and multiply sum
   assign load_dbl = {bank_data, bank_data};
   assign load_rot = load_dbl[{m_ff.addr[2:0], 3'b000} +: 64];

   always_comb begin
      case (m_ff.size)
         SZ_BYTE: load_val = {56'd0, load_rot[7:0]};
         SZ_HALF: load_val = {48'd0, load_rot[15:0]};
         default: load_val = load_rot;
      endcase
      if (!m_ff.we) begin
         m_final = 64'd0;
      end else if (m_ff.mem_rd) begin
         m_final = load_val;
      end else if (m_ff.is_mul) begin
         m_final = m_ff.pp_lo + {m_ff.pp_cross, 32'd0};
      end else begin
         m_final = m_ff.value;
      end
   end

   always_comb begin
      o_in.next_pc       = m_ff.next_pc;
      o_in.reg_written   = m_ff.we;
      o_in.reg_index     = m_ff.we ? m_ff.idx : 5'd0;
      o_in.reg_value     = m_final;
      o_in.negative_flag = m_ff.flag_n;
      o_in.zero_flag     = m_ff.flag_z;
      o_in.halted        = m_ff.halt;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff    <= 1'b0;
         m_vld_ff    <= 1'b0;
         o_vld_ff    <= 1'b0;
         pc_ff       <= START_PC_RESET;
         flag_n_ff   <= 1'b0;
         flag_z_ff   <= 1'b0;
         halted_ff   <= 1'b0;
         start_pc_ff <= START_PC_RESET;
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            start_pc_ff <= csr_wr_data;
         end
         if (clr_busy_ff) begin
            clr_row_ff <= clr_row_ff + RW'(1);
            if (clr_row_ff == RW'(ROWS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (adv) begin
            x_vld_ff <= accept;
            m_vld_ff <= x_vld_ff;
            o_vld_ff <= m_vld_ff;
            if (x_vld_ff) begin
               pc_ff     <= ex.next_pc;
               flag_n_ff <= ex.flag_n;
               flag_z_ff <= ex.flag_z;
               halted_ff <= ex.halt;
            end
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= req_payload;
         m_ff <= ex;
         o_ff <= o_in;
      end
   end

   assign rsp_valid   = o_vld_ff;
   assign rsp_payload = o_ff;

   a_csr_store: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> start_pc_ff == $past(csr_wr_data))
      else $error("start pc register lost a write");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !accept)
      else $error("transfer accepted during memory clear");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.reg_written |->
         rsp_payload.reg_index == 5'd0 && rsp_payload.reg_value == 64'd0)
      else $error("result without register write carries data");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt bit cleared");

endmodule
